### src/rla_pkg.sv
// shared types and constants of the running lcm accumulator
package rla_pkg;

  localparam int VALUE_PORT_BITS  = 16;
  localparam int RESULT_PORT_BITS = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_GCD_GO,
    S_GCD_WAIT,
    S_QUOT_GO,
    S_QUOT_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINISH
  } state_e;

endpackage

### src/rla_div.sv
// iterative restoring divider, one quotient bit per cycle
module rla_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  dsr_q;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // shift in the next dividend bit and try to subtract the divisor
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### src/rla_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module rla_mul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] product_o
);

  localparam int CW = $clog2(BW + 1);
  localparam int PW = AW + BW;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] mcand_q;
  logic [BW-1:0] mplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q   <= '0;
      mcand_q  <= PW'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

### src/running_lcm_accumulator_core.sv
// Running LCM accumulator: one unsigned value per request, the LCM of the set is
// returned on the request marked last, saturated to all ones with a sticky overflow
// flag. A request that starts a set, hits a zero or follows an overflow skips the
// arithmetic. Otherwise the update runs Euclid's gcd on one shared restoring divider
// of width W, the wider of VALUE_BITS and RESULT_BITS, then one more division for
// value/gcd and a shift-add multiply. The block takes no request while busy; a
// finished result sits in an output register until taken, and a request marked last
// waits at the end of its update while an earlier result is still untaken.
module running_lcm_accumulator_core
  import rla_pkg::*;
#(
  parameter int VALUE_BITS  = 16,
  parameter int RESULT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [VALUE_PORT_BITS-1:0]  value_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [RESULT_PORT_BITS-1:0] lcm_value_o,
  output logic                        overflowed_o
);

  localparam int W  = (RESULT_BITS > VALUE_BITS) ? RESULT_BITS : VALUE_BITS;
  localparam int PW = RESULT_BITS + VALUE_BITS;

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0]       v_q;
  logic                        last_q;
  logic [RESULT_BITS-1:0]      acc_q;
  logic                        started_q;
  logic                        ovf_q;
  logic [W-1:0]                x_q;
  logic [W-1:0]                y_q;
  logic                        out_valid_q;
  logic [RESULT_PORT_BITS-1:0] out_lcm_q;
  logic                        out_ovf_q;

  logic                        div_start;
  logic [W-1:0]                div_dividend;
  logic [W-1:0]                div_divisor;
  logic                        div_done;
  logic [W-1:0]                div_quo;
  logic [W-1:0]                div_rem;
  logic                        mul_start;
  logic                        mul_done;
  logic [PW-1:0]               mul_prod;

  logic                        in_fire;
  logic                        out_free;
  logic                        skip_math;
  logic                        v_fits;
  logic                        emit;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign v_fits   = ((W'(v_q) >> RESULT_BITS) == '0);
  assign skip_math = !started_q || ovf_q || (acc_q == '0) || (v_q == '0);

  rla_div #(
    .W(W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  rla_mul #(
    .AW(RESULT_BITS),
    .BW(VALUE_BITS)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (acc_q),
    .b_i       (div_quo[VALUE_BITS-1:0]),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = skip_math ? S_FINISH : S_GCD_GO;
      end
      S_GCD_GO: state_d = S_GCD_WAIT;
      S_GCD_WAIT: begin
        if (div_done) begin
          state_d = (div_rem == '0) ? S_QUOT_GO : S_GCD_GO;
        end
      end
      S_QUOT_GO: state_d = S_QUOT_WAIT;
      S_QUOT_WAIT: begin
        if (div_done) state_d = S_MUL_GO;
      end
      S_MUL_GO: state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!last_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    div_dividend = x_q;
    div_divisor  = y_q;
    emit         = 1'b0;
    case (state_q)
      S_IDLE:    in_ready_o = 1'b1;
      S_GCD_GO:  div_start  = 1'b1;
      S_QUOT_GO: begin
        div_start    = 1'b1;
        div_dividend = W'(v_q);
        div_divisor  = x_q;
      end
      S_MUL_GO:  mul_start  = 1'b1;
      S_FINISH:  emit       = last_q && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_DECIDE: begin
          if (!started_q) begin
            started_q <= 1'b1;
            ovf_q     <= !v_fits;
            acc_q     <= v_fits ? RESULT_BITS'(v_q) : '1;
          end else if (!ovf_q && ((acc_q == '0) || (v_q == '0))) begin
            acc_q <= '0;
          end
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            if ((mul_prod >> RESULT_BITS) != '0) begin
              ovf_q <= 1'b1;
              acc_q <= '1;
            end else begin
              acc_q <= RESULT_BITS'(mul_prod);
            end
          end
        end
        S_FINISH: begin
          if (emit) begin
            started_q   <= 1'b0;
            ovf_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q    <= VALUE_BITS'(value_i);
      last_q <= last_item_i;
    end
    if ((state_q == S_DECIDE) && !skip_math) begin
      x_q <= W'(v_q);
      y_q <= W'(acc_q);
    end
    // euclid step: (x, y) <= (y, x mod y), gcd ends up in x
    if ((state_q == S_GCD_WAIT) && div_done) begin
      x_q <= y_q;
      y_q <= div_rem;
    end
    if (emit) begin
      out_lcm_q <= RESULT_PORT_BITS'(acc_q);
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lcm_value_o  = out_lcm_q;
  assign overflowed_o = out_ovf_q;

endmodule

### bench/running_lcm_accumulator_checker.sv
// checker of the running lcm accumulator: folds accepted values into a set lcm, compares results
module running_lcm_accumulator_checker
  import rla_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [VALUE_PORT_BITS-1:0]  value_i,
  input  logic                        last_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [RESULT_PORT_BITS-1:0] lcm_value_i,
  input  logic                        overflowed_i,
  output int                          mismatch_count_o,
  output int                          sets_pending_o,
  output int                          sets_checked_o,
  output int                          sets_saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LCM_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - RESULT_PORT_BITS);
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [RESULT_PORT_BITS-1:0] lcm;
    logic                        saturated;
  } set_result_t;

  set_result_t set_result_q[$];
  logic [63:0] running_lcm   = '0;
  logic        set_open      = 1'b0;
  logic        set_saturated = 1'b0;

  initial begin
    mismatch_count_o = 0;
    sets_pending_o   = 0;
    sets_checked_o   = 0;
    sets_saturated_o = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // one accepted value; a 16 bit value always fits the accumulator when loaded
  task automatic fold_value(input logic [VALUE_PORT_BITS-1:0] v, input logic is_last);
    logic [63:0] v_wide;
    logic [63:0] quot;
    v_wide = 64'(v);
    if (!set_open) begin
      set_open      = 1'b1;
      set_saturated = 1'b0;
      running_lcm   = v_wide;
    end else if (!set_saturated) begin
      if (running_lcm == 0 || v_wide == 0) begin
        running_lcm = '0;
      end else begin
        // divide first, then check the product against the result width
        quot = v_wide / euclid_gcd(v_wide, running_lcm);
        if (quot > LCM_MAX / running_lcm) begin
          set_saturated = 1'b1;
          running_lcm   = LCM_MAX;
        end else begin
          running_lcm = quot * running_lcm;
        end
      end
    end
    if (is_last) begin
      set_result_q.push_back('{lcm: RESULT_PORT_BITS'(set_saturated ? LCM_MAX : running_lcm),
                               saturated: set_saturated});
      set_open      = 1'b0;
      set_saturated = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin : watch
    set_result_t want;
    if (rst_ni) begin
      // results first: a request taken at this edge cannot have its result here yet
      if (out_valid_i && out_ready_i) begin
        if (set_result_q.size() == 0) begin
          report_mismatch($sformatf("result lcm %0h overflow %0b with no set pending",
                                    lcm_value_i, overflowed_i));
        end else begin
          want = set_result_q.pop_front();
          if (lcm_value_i !== want.lcm)
            report_mismatch($sformatf("lcm %0h, expected %0h", lcm_value_i, want.lcm));
          if (overflowed_i !== want.saturated)
            report_mismatch($sformatf("overflow flag %0b, expected %0b",
                                      overflowed_i, want.saturated));
          sets_checked_o++;
          if (want.saturated) sets_saturated_o++;
        end
      end
      if (in_valid_i && in_ready_i) fold_value(value_i, last_item_i);
      sets_pending_o = set_result_q.size();
    end
  end

endmodule

### bench/tb_running_lcm_accumulator_core.sv
// top of the running lcm accumulator bench: clock, reset, request and result traffic, verdict
module tb_running_lcm_accumulator_core
  import rla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 8_000_000;
  localparam int TARGET_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 1000;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic [VALUE_PORT_BITS-1:0]  value_i      = '0;
  logic                        last_item_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic [RESULT_PORT_BITS-1:0] lcm_value_o;
  logic                        overflowed_o;

  int mismatch_count;
  int sets_pending;
  int sets_checked;
  int sets_saturated;
  int cycle_count = 0;
  int send_burst  = 0;
  int take_burst  = 0;

  running_lcm_accumulator_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lcm_value_o  (lcm_value_o),
    .overflowed_o (overflowed_o)
  );

  running_lcm_accumulator_checker lcm_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .value_i          (value_i),
    .last_item_i      (last_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .lcm_value_i      (lcm_value_o),
    .overflowed_i     (overflowed_o),
    .mismatch_count_o (mismatch_count),
    .sets_pending_o   (sets_pending),
    .sets_checked_o   (sets_checked),
    .sets_saturated_o (sets_saturated)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("running_lcm_accumulator_core test failed");
      $finish;
    end
  end

  // idle cycles before the next request or result, with occasional back-to-back stretches
  function automatic int draw_idle(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(10, 50);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [VALUE_PORT_BITS-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF - 16'($urandom_range(0, 15));
      2, 3: return 16'($urandom_range(1, 64));
      4: return 16'(1) << $urandom_range(0, VALUE_PORT_BITS - 1);
      5: return 16'($urandom_range(1, 5000) * 12);
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_PORT_BITS-1:0] v, input logic is_last);
    int gap;
    gap = draw_idle(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= v;
    last_item_i <= is_last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // result side
  initial begin : result_taker
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_idle(take_burst);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin : stimulus
    int sent;
    int set_len;
    logic tiny_set;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-request sets
    send_value(16'd0, 1'b1);
    send_value(16'hFFFF, 1'b1);
    // zeros in a set
    send_value(16'd0, 1'b0);
    send_value(16'd0, 1'b1);
    send_value(16'd0, 1'b0);
    send_value(16'd7, 1'b1);
    send_value(16'd7, 1'b0);
    send_value(16'd0, 1'b1);
    // shared factor, and the largest product that still fits
    send_value(16'd12, 1'b0);
    send_value(16'd18, 1'b1);
    send_value(16'hFFFF, 1'b0);
    send_value(16'hFFFE, 1'b1);
    // overflow, then a zero that must not clear the saturation
    send_value(16'hFFFF, 1'b0);
    send_value(16'hFFFE, 1'b0);
    send_value(16'hFFFD, 1'b0);
    send_value(16'd0, 1'b1);
    // divisors of the accumulator
    send_value(16'h8000, 1'b0);
    send_value(16'h4000, 1'b0);
    send_value(16'd1, 1'b1);
    sent = 19;

    while (sent < TARGET_ITEMS) begin
      set_len  = $urandom_range(1, 8);
      // sets of small values mostly stay in range, wide ones mostly saturate
      tiny_set = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < set_len; k++) begin
        send_value(tiny_set ? 16'($urandom_range(1, 60)) : draw_value(), k == set_len - 1);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sets_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d values in directed and random sets with random request and result gaps",
             sent);
    $display("checked %0d set results, %0d of them saturated", sets_checked, sets_saturated);
    if (mismatch_count == 0 && sets_pending == 0) begin
      $display("running_lcm_accumulator_core test passed");
    end else begin
      $display("running_lcm_accumulator_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/rla_pkg.sv
src/rla_div.sv
src/rla_mul.sv
src/running_lcm_accumulator_core.sv
bench/running_lcm_accumulator_checker.sv
bench/tb_running_lcm_accumulator_core.sv
